[sv/cdq_pkg.sv]
// cdq_pkg: shared types and constants of the circular deque unit
// no dependencies
`default_nettype none

package cdq_pkg;

    localparam int VALUE_W = 32;
    localparam int CMD_W = 3;
    localparam int CAP_W = 6;
    localparam logic [CAP_W-1:0] CAP_RESET = 6'd32;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_BACK  = 3'd0,
        CMD_PUSH_FRONT = 3'd1,
        CMD_POP_BACK   = 3'd2,
        CMD_POP_FRONT  = 3'd3,
        CMD_DUMP       = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        STS_DATA      = 2'd0,
        STS_OVERFLOW  = 2'd1,
        STS_UNDERFLOW = 2'd2,
        STS_EMPTY     = 2'd3
    } t_status;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_DATA = 1'b1
    } t_state;

    typedef struct packed {
        t_cmd               cmd;
        logic [VALUE_W-1:0] value;
    } t_op;

endpackage

`default_nettype wire

[sv/cdq_front.sv]
// cdq_front: accepts input beats, drops unused command codes and queues the rest
// depends on cdq_pkg
`default_nettype none

module cdq_front (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire logic [cdq_pkg::CMD_W-1:0]   i_command,
    input  wire logic [cdq_pkg::VALUE_W-1:0] i_value,
    output logic                             o_op_valid,
    input  wire logic                        i_op_ready,
    output cdq_pkg::t_op                     o_op
);

    cdq_pkg::t_op r_q [2];
    logic         r_wr, r_rd;
    logic [1:0]   r_cnt;
    logic         legal, push, pop;

    assign o_in_ready = (r_cnt != 2'd2);
    assign legal      = (i_command <= cdq_pkg::CMD_DUMP);
    assign push       = i_in_valid && o_in_ready && legal;
    assign o_op_valid = (r_cnt != 2'd0);
    assign pop        = o_op_valid && i_op_ready;
    assign o_op       = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wr <= ~r_wr;
            end
            if (pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= '{cmd: cdq_pkg::t_cmd'(i_command), value: i_value};
        end
    end

endmodule

`default_nettype wire

[sv/cdq_back.sv]
// cdq_back: executes queued commands on the slot ring and drives the result register
// depends on cdq_pkg
`default_nettype none

module cdq_back #(
    parameter int DEPTH      = 32,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_clear,
    input  wire logic [$clog2(DEPTH+1)-1:0]    i_cap,
    input  wire logic                          i_op_valid,
    output logic                               o_op_ready,
    input  wire cdq_pkg::t_op                  i_op,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [1:0]                         o_status,
    output logic [cdq_pkg::VALUE_W-1:0]        o_word,
    output logic                               o_last
);

    localparam int AW = $clog2(DEPTH + 1);
    localparam int MW = (DATA_WIDTH < cdq_pkg::VALUE_W) ? DATA_WIDTH : cdq_pkg::VALUE_W;

    logic [DATA_WIDTH-1:0] r_mem [DEPTH+1];
    logic [DATA_WIDTH-1:0] r_rdata;

    cdq_pkg::t_state           r_state, n_state;
    logic [AW-1:0]             r_head, n_head, r_tail, n_tail, r_count, n_count;
    logic [AW-1:0]             r_ptr, n_ptr, r_left, n_left;
    logic                      r_out_valid, n_out_valid;
    cdq_pkg::t_status          r_status, n_status;
    logic [cdq_pkg::VALUE_W-1:0] r_word, n_word;
    logic                      r_last, n_last;

    logic                  we, re, out_free, full, empty;
    logic [AW-1:0]         waddr, raddr, tail_dec, head_dec;
    logic [DATA_WIDTH-1:0] wdata;

    function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] idx,
                                               input logic [AW-1:0] cap);
        return (idx == cap) ? '0 : idx + 1'b1;
    endfunction

    function automatic logic [AW-1:0] ring_dec(input logic [AW-1:0] idx,
                                               input logic [AW-1:0] cap);
        return (idx == '0) ? cap : idx - 1'b1;
    endfunction

    assign out_free = !r_out_valid || i_out_ready;
    assign full     = (r_count == i_cap);
    assign empty    = (r_count == '0);
    assign tail_dec = ring_dec(r_tail, i_cap);
    assign head_dec = ring_dec(r_head, i_cap);
    assign wdata    = DATA_WIDTH'(i_op.value[MW-1:0]);

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_ptr       = r_ptr;
        n_left      = r_left;
        n_out_valid = r_out_valid;
        n_status    = r_status;
        n_word      = r_word;
        n_last      = r_last;
        o_op_ready  = 1'b0;
        we          = 1'b0;
        waddr       = r_tail;
        re          = 1'b0;
        raddr       = r_head;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            cdq_pkg::ST_IDLE: begin
                if (i_op_valid && out_free) begin
                    o_op_ready = 1'b1;
                    unique case (i_op.cmd)
                        cdq_pkg::CMD_PUSH_BACK, cdq_pkg::CMD_PUSH_FRONT: begin
                            if (full) begin
                                n_out_valid = 1'b1;
                                n_status    = cdq_pkg::STS_OVERFLOW;
                                n_word      = '0;
                                n_last      = 1'b1;
                            end else if (i_op.cmd == cdq_pkg::CMD_PUSH_BACK) begin
                                we      = 1'b1;
                                waddr   = r_tail;
                                n_tail  = ring_inc(r_tail, i_cap);
                                n_count = r_count + 1'b1;
                            end else begin
                                we      = 1'b1;
                                waddr   = head_dec;
                                n_head  = head_dec;
                                n_count = r_count + 1'b1;
                            end
                        end
                        cdq_pkg::CMD_POP_BACK, cdq_pkg::CMD_POP_FRONT: begin
                            if (empty) begin
                                n_out_valid = 1'b1;
                                n_status    = cdq_pkg::STS_UNDERFLOW;
                                n_word      = '0;
                                n_last      = 1'b1;
                            end else begin
                                re      = 1'b1;
                                n_count = r_count - 1'b1;
                                n_left  = AW'(1);
                                n_state = cdq_pkg::ST_DATA;
                                if (i_op.cmd == cdq_pkg::CMD_POP_BACK) begin
                                    raddr  = tail_dec;
                                    n_tail = tail_dec;
                                end else begin
                                    raddr  = r_head;
                                    n_head = ring_inc(r_head, i_cap);
                                end
                            end
                        end
                        cdq_pkg::CMD_DUMP: begin
                            if (empty) begin
                                n_out_valid = 1'b1;
                                n_status    = cdq_pkg::STS_EMPTY;
                                n_word      = '0;
                                n_last      = 1'b1;
                            end else begin
                                re      = 1'b1;
                                raddr   = r_head;
                                n_ptr   = ring_inc(r_head, i_cap);
                                n_left  = r_count;
                                n_state = cdq_pkg::ST_DATA;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            cdq_pkg::ST_DATA: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_status    = cdq_pkg::STS_DATA;
                    n_word      = cdq_pkg::VALUE_W'(r_rdata[MW-1:0]);
                    n_last      = (r_left == AW'(1));
                    if (r_left == AW'(1)) begin
                        n_state = cdq_pkg::ST_IDLE;
                    end else begin
                        re     = 1'b1;
                        raddr  = r_ptr;
                        n_ptr  = ring_inc(r_ptr, i_cap);
                        n_left = r_left - 1'b1;
                    end
                end
            end
            default: begin
                n_state = cdq_pkg::ST_IDLE;
            end
        endcase

        if (i_clear) begin
            n_head  = '0;
            n_tail  = '0;
            n_count = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cdq_pkg::ST_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr    <= n_ptr;
        r_left   <= n_left;
        r_status <= n_status;
        r_word   <= n_word;
        r_last   <= n_last;
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        if (re) begin
            r_rdata <= r_mem[raddr];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_word      = r_word;
    assign o_last      = r_last;

endmodule

`default_nettype wire

[sv/circular_deque_unit.sv]
// circular_deque_unit: double-ended queue of words on a ring of capacity+1 slots
// depends on cdq_pkg, cdq_front, cdq_back
//
// input channel: i_in_valid / o_in_ready carry a command and a value per beat;
// pushes go to the back or front, pops remove one word, dump streams all words
// output channel: o_out_valid / i_out_ready carry status, word and last per beat;
// a successful push gives no beat, every other known command ends on a beat with last
// a two-entry queue parts the input side from the executor, so input beats are
// taken while a result waits; unused command codes are taken and dropped
// push: a slot write in the executor; pop: slot read, then result register;
// dump: one word per cycle while the receiver does not stall, set by the single
// read port of the slot memory; no new command starts while a dump runs
// a stalled receiver holds the result register and the executor waits on it
// reset (synchronous, active low) empties the deque and sets capacity to 32;
// slot contents are not cleared and no clearing pass is needed
// config: capacity at byte address 0 over the apb port; a write empties the deque;
// the user must make it only while the unit is idle, the block does not enforce it
`default_nettype none

module circular_deque_unit #(
    parameter int DEPTH      = 32,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [2:0]                  paddr,
    input  wire logic [31:0]                 pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready,
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire logic [cdq_pkg::CMD_W-1:0]   i_command,
    input  wire logic [cdq_pkg::VALUE_W-1:0] i_value,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output logic [1:0]                       o_status,
    output logic [cdq_pkg::VALUE_W-1:0]      o_word,
    output logic                             o_last
);

    localparam int AW = $clog2(DEPTH + 1);

    logic [cdq_pkg::CAP_W-1:0] r_capacity;
    logic                      cfg_wr;
    logic [AW-1:0]             cap_eff;
    logic                      op_valid, op_ready;
    cdq_pkg::t_op              op;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
    assign prdata  = (paddr[2] == 1'b0) ? 32'(r_capacity) : 32'd0;
    assign cap_eff = (32'(r_capacity) > DEPTH) ? AW'(DEPTH) : AW'(r_capacity);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= cdq_pkg::CAP_RESET;
        end else if (cfg_wr) begin
            r_capacity <= pwdata[cdq_pkg::CAP_W-1:0];
        end
    end

    cdq_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_command  (i_command),
        .i_value    (i_value),
        .o_op_valid (op_valid),
        .i_op_ready (op_ready),
        .o_op       (op)
    );

    cdq_back #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_clear     (cfg_wr),
        .i_cap       (cap_eff),
        .i_op_valid  (op_valid),
        .o_op_ready  (op_ready),
        .i_op        (op),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_status    (o_status),
        .o_word      (o_word),
        .o_last      (o_last)
    );

endmodule

`default_nettype wire
